[rtl/class_priority_task_queue_core_defines.svh]
// assertion macros used by the checker file of the task queue core
// depends on signals clk and rst being visible where a macro is used
`ifndef CLASS_PRIORITY_TASK_QUEUE_CORE_DEFINES_SVH
`define CLASS_PRIORITY_TASK_QUEUE_CORE_DEFINES_SVH

// plain property, sampled on clk, off during reset
`define CPTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// overlapping implication, sampled on clk, off during reset
`define CPTQ_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/cptq_pkg.sv]
// shared types and constants of the class priority task queue
// used by the core, its tag memory and its port checker
package cptq_pkg;

  // field widths fixed by the stream format
  localparam int TAG_W      = 16;
  localparam int CLASS_W    = 3;
  localparam int OCC_W      = 5;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 24;

  // default sizing
  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_NUM_CLASSES = 5;

  // lowest service class, reported on results that carry no task
  localparam logic [CLASS_W-1:0] BACKGROUND = 3'd0;

  // item kind carried in tuser on the input side
  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_TAKE   = 1'b1;

  // result status carried in tuser on the output side
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_PAUSED = 2'd3
  } status_t;

endpackage

[rtl/cptq_store.sv]
// tag memory of the task queue: one write port, one registered read port
// depends on cptq_pkg for the tag width
module cptq_store #(
  parameter int DEPTH  = 80,
  parameter int ADDR_W = 7
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [cptq_pkg::TAG_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [cptq_pkg::TAG_W-1:0] rd_data
);
  import cptq_pkg::*;

  logic [TAG_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/class_priority_task_queue_core.sv]
// Strict-priority task queue with NUM_CLASSES service classes, first in first out inside a
// class, at most CAPACITY tasks in total. A submit word writes its tag into the tag memory
// and registers its result at once. A take that finds a task passes through S_READ while the
// registered read port of the tag memory delivers its tag; the block accepts no word while
// such a take waits for its read. A take on an empty queue registers its result at once, like
// a submit. A new word is accepted while the previous result is being taken from the output
// register, so a stream of submits runs at one word per cycle while the output does not
// stall. Tags live in one memory of NUM_CLASSES*CAPACITY entries (one ring per class); ring
// heads, tails and counts are registers, and the highest nonempty class is found by a
// priority encoder over the class counts. A submitted class above NUM_CLASSES-1 counts as
// NUM_CLASSES-1. The paused register drops every submit; takes are still served.
// depends on cptq_pkg and cptq_store
module class_priority_task_queue_core #(
  parameter int CAPACITY    = cptq_pkg::DEF_CAPACITY,
  parameter int NUM_CLASSES = cptq_pkg::DEF_NUM_CLASSES
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cptq_pkg::IN_TDATA_W-1:0]   s_tdata,  // task_class[2:0], task_tag[18:3], zero
  input  logic                              s_tuser,  // func[0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cptq_pkg::OUT_TDATA_W-1:0]  m_tdata,  // out_tag[15:0], out_class[18:16],
                                                      // occupancy[23:19]
  output logic [1:0]                        m_tuser,  // status[1:0]
  // paused register
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);
  import cptq_pkg::*;

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = NUM_CLASSES * CAPACITY;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t             state;
  logic               paused;
  logic [IDX_W-1:0]   heads  [NUM_CLASSES];
  logic [IDX_W-1:0]   tails  [NUM_CLASSES];
  logic [CNT_W-1:0]   counts [NUM_CLASSES];
  logic [CNT_W-1:0]   total;

  logic               out_valid;
  logic               out_valid_next;
  status_t            out_status;
  logic [TAG_W-1:0]   out_tag;
  logic [CLASS_W-1:0] out_class;
  logic [OCC_W-1:0]   out_occ;

  logic               in_acc;
  logic               is_take;
  logic [CLASS_W-1:0] in_class;
  logic [TAG_W-1:0]   in_tag;
  logic [CLS_W-1:0]   cls_sat;
  logic               any_task;
  logic [CLS_W-1:0]   pick;
  logic [IDX_W-1:0]   head_inc;
  logic [IDX_W-1:0]   tail_inc;
  logic               sub_ok;
  logic               take_hit;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [TAG_W-1:0]   rd_data;

  // handshakes and field unpacking
  assign s_tready  = (state == S_IDLE) && (!out_valid || m_tready);
  assign in_acc    = s_tvalid && s_tready;
  assign is_take   = (s_tuser == FUNC_TAKE);
  assign in_class  = s_tdata[CLASS_W-1:0];
  assign in_tag    = s_tdata[CLASS_W +: TAG_W];
  assign cfg_ready = 1'b1;

  // clamp the submitted class to the top class
  always_comb begin
    if (int'(in_class) > NUM_CLASSES - 1) begin
      cls_sat = CLS_W'(NUM_CLASSES - 1);
    end else begin
      cls_sat = CLS_W'(in_class);
    end
  end

  // highest nonempty class
  always_comb begin
    any_task = 1'b0;
    pick     = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (counts[c] != '0) begin
        any_task = 1'b1;
        pick     = CLS_W'(c);
      end
    end
  end

  // ring index advance
  assign head_inc = (heads[pick] == IDX_W'(CAPACITY - 1)) ? '0 : heads[pick] + 1'b1;
  assign tail_inc = (tails[cls_sat] == IDX_W'(CAPACITY - 1)) ? '0 : tails[cls_sat] + 1'b1;

  // what the accepted word does to the queue
  assign sub_ok   = in_acc && !is_take && !paused && (total < CNT_W'(CAPACITY));
  assign take_hit = in_acc && is_take && any_task;

  // output register valid: held while stalled, set by a finished word
  always_comb begin
    out_valid_next = out_valid && !m_tready;
    if ((in_acc && !take_hit) || (state == S_READ)) begin
      out_valid_next = 1'b1;
    end
  end

  // tag memory accesses
  assign wr_en   = sub_ok;
  assign wr_addr = ADDR_W'(cls_sat) * ADDR_W'(CAPACITY) + ADDR_W'(tails[cls_sat]);
  assign rd_en   = take_hit;
  assign rd_addr = ADDR_W'(pick) * ADDR_W'(CAPACITY) + ADDR_W'(heads[pick]);

  cptq_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tag),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state: sequencer, ring pointers, counts, paused, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      paused    <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads[c]  <= '0;
        tails[c]  <= '0;
        counts[c] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        paused <= cfg_data;
      end
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: begin
          if (sub_ok) begin
            tails[cls_sat]  <= tail_inc;
            counts[cls_sat] <= counts[cls_sat] + 1'b1;
            total           <= total + 1'b1;
          end
          if (take_hit) begin
            heads[pick]  <= head_inc;
            counts[pick] <= counts[pick] - 1'b1;
            total        <= total - 1'b1;
            state        <= S_READ;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tag <= '0;
      if (is_take) begin
        if (any_task) begin
          out_status <= ST_OK;
          out_class  <= CLASS_W'(pick);
          out_occ    <= OCC_W'(total - 1'b1);
        end else begin
          out_status <= ST_EMPTY;
          out_class  <= BACKGROUND;
          out_occ    <= OCC_W'(total);
        end
      end else begin
        out_class <= BACKGROUND;
        if (paused) begin
          out_status <= ST_PAUSED;
          out_occ    <= OCC_W'(total);
        end else if (!sub_ok) begin
          out_status <= ST_FULL;
          out_occ    <= OCC_W'(total);
        end else begin
          out_status <= ST_OK;
          out_occ    <= OCC_W'(total + 1'b1);
        end
      end
    end else if (state == S_READ) begin
      out_tag <= rd_data;
    end
  end

  // output packing
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_occ, out_class, out_tag};
  assign m_tuser  = out_status;

endmodule

[rtl/cptq_checker.sv]
// port-level checks of the class priority task queue, bound to the core
// depends on cptq_pkg and class_priority_task_queue_core_defines.svh
`include "class_priority_task_queue_core_defines.svh"

module cptq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [cptq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic [1:0]                        m_tuser
);
  import cptq_pkg::*;

  logic s_acc;
  logic out_stall;
  logic sub_acc;
  logic take_acc;
  assign s_acc     = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;
  assign sub_acc   = s_acc && (s_tuser == FUNC_SUBMIT);
  assign take_acc  = s_acc && (s_tuser == FUNC_TAKE);

  // a stalled result word holds its payload
  `CPTQ_ASSERT(a_out_hold, out_stall |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

  // no word is accepted while an unread result blocks the output register
  `CPTQ_IMPLY(a_no_overrun, out_stall, !s_tready, "input accepted over a stalled result")

  // a submit yields its result on the next cycle and never reports empty
  `CPTQ_ASSERT(a_submit_result, sub_acc |=> (m_tvalid && m_tuser != ST_EMPTY), "bad submit result")

  // a take either reports empty at once or blocks input while the tag is read
  `CPTQ_ASSERT(a_take_result, take_acc |=> ((m_tvalid && m_tuser == ST_EMPTY) || !s_tready), "take not sequenced")

  // empty, full and paused results carry no task
  `CPTQ_IMPLY(a_no_task, m_tvalid && m_tuser != ST_OK, m_tdata[18:0] == 19'd0, "task fields set")

endmodule

bind class_priority_task_queue_core cptq_checker u_cptq_checker (.*);
